// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion macros for the page table walk checker
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");

// next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");

`endif

// ===== design/ptw_pkg.sv =====
// ---------------------------------------------------------------------------
// ptw_pkg
// widths, field positions and codes of the four level page table walk
// ---------------------------------------------------------------------------
package ptw_pkg;

   // field widths
   localparam int CMD_W        = 1;
   localparam int ENTRY_ADDR_W = 53;
   localparam int ENTRY_VAL_W  = 64;
   localparam int LA_W         = 48;
   localparam int PA_W         = 52;
   localparam int OFFSET_W     = 12;
   localparam int IDX_BITS     = 9;
   localparam int PTE_SHIFT    = 3;

   // translation levels, top level first
   localparam int LEVELS  = 4;
   localparam int LVL_W   = 2;
   localparam int L0_LSB  = 39;
   localparam int L1_LSB  = 30;
   localparam int L2_LSB  = 21;
   localparam int L3_LSB  = 12;

   // frame field of a table entry
   localparam int FRAME_LSB = 12;
   localparam int FRAME_MSB = 51;
   localparam int FRAME_W   = FRAME_MSB - FRAME_LSB + 1;
   localparam int PRESENT_BIT = 0;

   // request tdata layout, lowest first
   localparam int REQ_EADDR_LSB = 0;
   localparam int REQ_EVAL_LSB  = REQ_EADDR_LSB + ENTRY_ADDR_W;
   localparam int REQ_LA_LSB    = REQ_EVAL_LSB + ENTRY_VAL_W;
   localparam int REQ_USED_W    = REQ_LA_LSB + LA_W;
   localparam int REQ_TDATA_W   = ((REQ_USED_W + 7) / 8) * 8;
   localparam int REQ_TUSER_W   = CMD_W;

   // response tdata layout
   localparam int RSP_TDATA_W = ((PA_W + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_TDATA_W - PA_W;
   localparam int RSP_TUSER_W = 1;

   // command codes
   localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
   localparam logic [CMD_W-1:0] CMD_XLATE = 1'b1;

   typedef logic [ENTRY_ADDR_W-1:0] entry_addr_type;
   typedef logic [ENTRY_VAL_W-1:0]  entry_val_type;
   typedef logic [LA_W-1:0]         la_type;
   typedef logic [PA_W-1:0]         pa_type;
   typedef logic [IDX_BITS-1:0]     idx_type;

endpackage

// ===== design/ptw_ram.sv =====
// ---------------------------------------------------------------------------
// ptw_ram
// generic single write port, single read port ram with registered read
// ---------------------------------------------------------------------------
module ptw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/four_level_page_table_walk_core.sv =====
// ---------------------------------------------------------------------------
// four_level_page_table_walk_core
// four level page table walk over a loaded table of address/value pairs
// ---------------------------------------------------------------------------
//
//  channel  dir  handshake              payload
//  req      in   req_tvalid/req_tready  tuser: cmd; tdata: entry fields, logical addr
//  rsp      out  rsp_tvalid/rsp_tready  tuser: fault; tdata: physical address
//  csr      in   csr_valid/csr_ready    csr_data: root table base
//
//  a load item is written to the table ram as it is taken, unless the store is
//  full; a translate item walks the levels in turn, and every level scans the
//  table ram newest first through its one read port and one comparator
//  reset clears the fill count, the root register and the output; ram
//  contents are not cleared, entries at or above the fill count are never read
//  a result waits in the output register; new items are taken meanwhile, a
//  finished walk holds until that register is free
//
module four_level_page_table_walk_core #(
   parameter int TABLE_ENTRIES = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   // req_tuser: cmd
   // req_tdata: entry_address, entry_value, logical_address, zero pad
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [ptw_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  logic [ptw_pkg::REQ_TUSER_W-1:0]  req_tuser,
   // rsp_tdata: physical_address, zero pad
   // rsp_tuser: fault
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [ptw_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic [ptw_pkg::RSP_TUSER_W-1:0]  rsp_tuser,
   // root table base write
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ptw_pkg::PA_W-1:0]         csr_data
);

   import ptw_pkg::*;

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam int RAM_W = ENTRY_ADDR_W + ENTRY_VAL_W;
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_ENTRIES);
   localparam logic [LVL_W-1:0] LVL_LAST = LVL_W'(LEVELS - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_STEP,
      ST_SCAN,
      ST_RESP
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] scan_idx_ff, scan_idx_in;
   logic             pend_ff, pend_in;
   logic [LVL_W-1:0] level_ff, level_in;
   la_type           la_ff, la_in;
   pa_type           base_ff, base_in;
   entry_addr_type   addr_ff, addr_in;
   pa_type           root_ff, root_in;
   pa_type           res_pa_ff, res_pa_in;
   logic             res_fault_ff, res_fault_in;
   logic             rsp_valid_ff, rsp_valid_in;
   pa_type           rsp_pa_ff, rsp_pa_in;
   logic             rsp_fault_ff, rsp_fault_in;

   logic             req_accept;
   logic             req_cmd;
   entry_addr_type   req_eaddr;
   entry_val_type    req_eval;
   la_type           req_la;

   logic             ram_we;
   logic             ram_re;
   logic [RAM_W-1:0] ram_wdata;
   logic [RAM_W-1:0] ram_rdata;
   entry_addr_type   rd_key;
   entry_val_type    rd_val;
   logic [CNT_W-1:0] scan_dec;
   logic             hit;
   idx_type          level_idx;
   entry_addr_type   step_addr;

   // request fields
   assign req_cmd    = req_tuser[0];
   assign req_eaddr  = req_tdata[REQ_EADDR_LSB +: ENTRY_ADDR_W];
   assign req_eval   = req_tdata[REQ_EVAL_LSB +: ENTRY_VAL_W];
   assign req_la     = req_tdata[REQ_LA_LSB +: LA_W];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // table store: key in the low bits, value above
   assign ram_we    = req_accept && (req_cmd == CMD_LOAD) && (count_ff < CNT_FULL);
   assign ram_wdata = {req_eval, req_eaddr};
   assign rd_key    = ram_rdata[ENTRY_ADDR_W-1:0];
   assign rd_val    = ram_rdata[RAM_W-1:ENTRY_ADDR_W];
   assign scan_dec  = scan_idx_ff - CNT_W'(1);
   assign hit       = pend_ff && (rd_key == addr_ff);
   assign ram_re    = (state_ff == ST_SCAN) && (scan_idx_ff != '0) && !hit;

   ptw_ram #(
      .WIDTH (RAM_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_ptw_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (scan_dec[IDX_W-1:0]),
      .rd_data (ram_rdata)
   );

   // index field of the current level
   always_comb begin
      unique case (level_ff)
         2'd0:    level_idx = la_ff[L0_LSB +: IDX_BITS];
         2'd1:    level_idx = la_ff[L1_LSB +: IDX_BITS];
         2'd2:    level_idx = la_ff[L2_LSB +: IDX_BITS];
         default: level_idx = la_ff[L3_LSB +: IDX_BITS];
      endcase
   end

   // entry address: base plus index times eight
   assign step_addr = ENTRY_ADDR_W'(base_ff)
                    + ENTRY_ADDR_W'({level_idx, {PTE_SHIFT{1'b0}}});

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      scan_idx_in  = scan_idx_ff;
      pend_in      = pend_ff;
      level_in     = level_ff;
      la_in        = la_ff;
      base_in      = base_ff;
      addr_in      = addr_ff;
      root_in      = root_ff;
      res_pa_in    = res_pa_ff;
      res_fault_in = res_fault_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_pa_in    = rsp_pa_ff;
      rsp_fault_in = rsp_fault_ff;

      if (csr_valid) begin
         root_in = csr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_cmd == CMD_LOAD) begin
                  if (count_ff < CNT_FULL) begin
                     count_in = count_ff + CNT_W'(1);
                  end
               end else begin
                  la_in    = req_la;
                  base_in  = root_ff;
                  level_in = '0;
                  state_in = ST_STEP;
               end
            end
         end
         ST_STEP: begin
            addr_in     = step_addr;
            scan_idx_in = count_ff;
            pend_in     = 1'b0;
            state_in    = ST_SCAN;
         end
         ST_SCAN: begin
            if (hit) begin
               pend_in = 1'b0;
               if (!rd_val[PRESENT_BIT]) begin
                  // entry not present
                  res_pa_in    = '0;
                  res_fault_in = 1'b1;
                  state_in     = ST_RESP;
               end else if (level_ff == LVL_LAST) begin
                  res_pa_in    = {rd_val[FRAME_MSB:FRAME_LSB], la_ff[OFFSET_W-1:0]};
                  res_fault_in = 1'b0;
                  state_in     = ST_RESP;
               end else begin
                  base_in  = {rd_val[FRAME_MSB:FRAME_LSB], {FRAME_LSB{1'b0}}};
                  level_in = level_ff + LVL_W'(1);
                  state_in = ST_STEP;
               end
            end else if (scan_idx_ff != '0) begin
               // read the next older entry
               scan_idx_in = scan_dec;
               pend_in     = 1'b1;
            end else begin
               // no entry at this address
               pend_in      = 1'b0;
               res_pa_in    = '0;
               res_fault_in = 1'b1;
               state_in     = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_pa_in    = res_pa_ff;
               rsp_fault_in = res_fault_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         scan_idx_ff  <= '0;
         pend_ff      <= 1'b0;
         level_ff     <= '0;
         root_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         scan_idx_ff  <= scan_idx_in;
         pend_ff      <= pend_in;
         level_ff     <= level_in;
         la_ff        <= la_in;
         base_ff      <= base_in;
         addr_ff      <= addr_in;
         root_ff      <= root_in;
         res_pa_ff    <= res_pa_in;
         res_fault_ff <= res_fault_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_pa_ff    <= rsp_pa_in;
         rsp_fault_ff <= rsp_fault_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_pa_ff};
   assign rsp_tuser  = rsp_fault_ff;

endmodule

// ===== design/ptw_checker.sv =====
// ---------------------------------------------------------------------------
// ptw_checker
// port level checks of the page table walk core, bound to the top level
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ptw_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [ptw_pkg::REQ_TUSER_W-1:0]  req_tuser,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [ptw_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input logic [ptw_pkg::RSP_TUSER_W-1:0]  rsp_tuser
);

   import ptw_pkg::*;

   logic xlate_accept;
   logic rsp_stall;

   assign xlate_accept = req_tvalid && req_tready && (req_tuser[0] == CMD_XLATE);
   assign rsp_stall    = rsp_tvalid && !rsp_tready;

   // a stalled result item holds its payload
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall,
                rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // a faulting walk reports a zero address
   `ASSERT_SAME(a_fault_zero, clock, reset, rsp_tvalid && rsp_tuser[0],
                rsp_tdata == '0)

   // a walk blocks the request side while it runs
   `ASSERT_NEXT(a_walk_busy, clock, reset, xlate_accept, !req_tready)

   // no result item appears the cycle after a walk starts
   `ASSERT_NEXT(a_walk_latency, clock, reset, xlate_accept, !$rose(rsp_tvalid))

endmodule

bind four_level_page_table_walk_core ptw_checker u_ptw_checker (.*);

// ===== bench/ptw_walk_checker.sv =====
// ---------------------------------------------------------------------------
// ptw_walk_checker
// watches the request, result and root register channels of the page table
// walk core, keeps its own copy of the loaded memory and the root register,
// predicts each translate result and compares it with what the core returns
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module ptw_walk_checker #(
   parameter int STORE_DEPTH = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   // req_tuser: cmd
   // req_tdata: entry_address, entry_value, logical_address, zero pad
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [ptw_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  logic [ptw_pkg::REQ_TUSER_W-1:0]  req_tuser,
   // rsp_tdata: physical_address, zero pad
   // rsp_tuser: fault
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [ptw_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input  logic [ptw_pkg::RSP_TUSER_W-1:0]  rsp_tuser,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [ptw_pkg::PA_W-1:0]         csr_data,
   output int                               mismatch_count,
   output int                               results_owed
);
   import ptw_pkg::*;

   typedef struct packed {
      pa_type xlate_pa;
      logic   fault;
   } xlate_result_type;

   // translate results still owed by the core, oldest first
   xlate_result_type owed_results[$];
   xlate_result_type got;
   xlate_result_type want;

   // loaded memory as address/value pairs in load order
   entry_addr_type page_mem_addr[STORE_DEPTH];
   entry_val_type  page_mem_data[STORE_DEPTH];
   int unsigned    page_mem_fill;
   pa_type         root_base;

   // four level walk over the loaded pairs, stops at the first bad level
   function automatic xlate_result_type walk_tables(input la_type va);
      entry_addr_type   tbl_base;
      entry_addr_type   slot;
      entry_val_type    pte;
      logic             found;
      xlate_result_type res;
      res      = '0;
      tbl_base = entry_addr_type'(root_base);
      for (int lvl = 0; lvl < LEVELS; lvl++) begin
         slot  = tbl_base
               + (entry_addr_type'(va[L0_LSB - IDX_BITS * lvl +: IDX_BITS]) << PTE_SHIFT);
         found = 1'b0;
         pte   = '0;
         // newest pair wins when addresses repeat
         for (int i = int'(page_mem_fill) - 1; i >= 0 && !found; i--) begin
            if (page_mem_addr[i] == slot) begin
               found = 1'b1;
               pte   = page_mem_data[i];
            end
         end
         if (!found || !pte[PRESENT_BIT]) begin
            res.fault = 1'b1;
            return res;
         end
         tbl_base = '0;
         tbl_base[FRAME_MSB:FRAME_LSB] = pte[FRAME_MSB:FRAME_LSB];
      end
      res.xlate_pa = tbl_base[PA_W-1:0] | pa_type'(va[OFFSET_W-1:0]);
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         root_base     = '0;
         page_mem_fill = 0;
         owed_results.delete();
         results_owed  = 0;
      end else begin
         // root register write
         if (csr_valid && csr_ready) begin
            root_base = csr_data;
         end
         // request item: a load fills the store unless full, a translate owes a result
         if (req_tvalid && req_tready) begin
            if (req_tuser == CMD_LOAD) begin
               if (page_mem_fill < STORE_DEPTH) begin
                  page_mem_addr[page_mem_fill] = req_tdata[REQ_EADDR_LSB +: ENTRY_ADDR_W];
                  page_mem_data[page_mem_fill] = req_tdata[REQ_EVAL_LSB +: ENTRY_VAL_W];
                  page_mem_fill++;
               end
            end else begin
               owed_results.push_back(walk_tables(req_tdata[REQ_LA_LSB +: LA_W]));
            end
         end
         // result item against the oldest owed result
         if (rsp_tvalid && rsp_tready) begin
            got.xlate_pa = rsp_tdata[PA_W-1:0];
            got.fault    = rsp_tuser[0];
            if (owed_results.size() == 0) begin
               mismatch_count++;
               $display("%0t: result with none expected: physical_address %h fault %b",
                        $time, got.xlate_pa, got.fault);
            end else begin
               want = owed_results.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  $display("%0t: expected physical_address %h fault %b, actual %h fault %b",
                           $time, want.xlate_pa, want.fault, got.xlate_pa, got.fault);
               end
            end
         end
         results_owed = owed_results.size();
      end
   end

endmodule

// ===== bench/tb_four_level_page_table_walk_core.sv =====
// ---------------------------------------------------------------------------
// tb_four_level_page_table_walk_core
// drives load and translate items into the page table walk core: a short
// directed set of edge walks, then random page mappings built level by level
// and translated, under three root register settings, ending with the store
// filled past capacity; a separate checker predicts and compares the results
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_four_level_page_table_walk_core;
   import ptw_pkg::*;

   localparam int     STORE_DEPTH   = 256;
   // longest walk over a full store plus margin
   localparam int     SETTLE_CYCLES = 4 * (STORE_DEPTH + 2) + 1 + 16;
   localparam int     HOLD_CYCLES   = 600;
   localparam int     IDLE_PCT      = 14;
   localparam int     TIMEOUT_NS    = 30_000_000;
   localparam pa_type ROOT_MAX      = '1;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_TDATA_W-1:0]  req_tdata  = '0;
   logic [REQ_TUSER_W-1:0]  req_tuser  = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]  rsp_tdata;
   logic [RSP_TUSER_W-1:0]  rsp_tuser;
   logic                    csr_valid  = 1'b0;
   logic                    csr_ready;
   logic [PA_W-1:0]         csr_data   = '0;

   int     mismatch_count;
   int     results_owed;
   logic   no_stall   = 1'b0;
   int     hold_asked = 0;
   int     items_sent = 0;
   int     loads_sent = 0;
   pa_type root_now   = '0;

   // a page mapped by the bench: its logical address and the table base per level
   typedef struct packed {
      la_type                              va;
      logic [LEVELS-1:0][ENTRY_ADDR_W-1:0] tbl;
   } page_map_type;

   page_map_type known_maps[$];

   four_level_page_table_walk_core #(
      .TABLE_ENTRIES(STORE_DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   ptw_walk_checker #(
      .STORE_DEPTH(STORE_DEPTH)
   ) walk_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .results_owed   (results_owed)
   );

   // clock
   initial begin
      forever #4 clock = ~clock;
   end

   // run limit
   initial begin
      #(TIMEOUT_NS);
      $display("TEST FAILED");
      $finish;
   end

   // result side: random backpressure plus long holds on request
   initial begin : result_sink
      int hold_left;
      int hold_served;
      hold_left   = 0;
      hold_served = 0;
      forever begin
         @(posedge clock);
         if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            hold_left   = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= no_stall || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic idx_type idx_of(input la_type va, input int lvl);
      return va[L0_LSB - IDX_BITS * lvl +: IDX_BITS];
   endfunction

   // offer one item, with an occasional idle gap ahead of it
   task automatic send_item(input logic [CMD_W-1:0] cmd, input entry_addr_type ea,
                            input entry_val_type ev, input la_type va);
      int gap;
      if (!no_stall && $urandom_range(99) < IDLE_PCT) begin
         gap = ($urandom_range(9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tuser  <= cmd;
      req_tdata  <= {{(REQ_TDATA_W - REQ_USED_W){1'b0}}, va, ev, ea};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      if (cmd == CMD_LOAD) begin
         loads_sent++;
      end
   endtask

   // stop offering until every owed result is back, then let the core settle
   task automatic drain_results(input int settle);
      req_tvalid <= 1'b0;
      do @(negedge clock); while (results_owed != 0);
      @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_root(input pa_type value);
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      root_now = value;
      known_maps.delete();
   endtask

   // map a random page, sharing upper levels with a known page at times, then translate it
   task automatic map_new_page();
      page_map_type   parent;
      page_map_type   m;
      int             keep;
      entry_addr_type base;
      entry_val_type  pte;
      m.va     = la_type'(rand64());
      m.tbl    = '0;
      m.tbl[0] = entry_addr_type'(root_now);
      keep     = 0;
      if (known_maps.size() > 0 && $urandom_range(99) < 60) begin
         parent = known_maps[$urandom_range(known_maps.size() - 1)];
         keep   = $urandom_range(LEVELS - 1);
         m.tbl  = parent.tbl;
         for (int lvl = 0; lvl < keep; lvl++) begin
            m.va[L0_LSB - IDX_BITS * lvl +: IDX_BITS] = idx_of(parent.va, lvl);
         end
      end
      base = m.tbl[keep];
      // one fresh entry per level below the shared part
      for (int lvl = keep; lvl < LEVELS; lvl++) begin
         m.tbl[lvl]       = base;
         pte              = rand64();
         pte[PRESENT_BIT] = ($urandom_range(99) >= 5);
         send_item(CMD_LOAD, base + (entry_addr_type'(idx_of(m.va, lvl)) << PTE_SHIFT),
                   pte, la_type'(rand64()));
         base = '0;
         base[FRAME_MSB:FRAME_LSB] = pte[FRAME_MSB:FRAME_LSB];
      end
      known_maps.push_back(m);
      m.va[OFFSET_W-1:0] = OFFSET_W'($urandom);
      send_item(CMD_XLATE, entry_addr_type'(rand64()), rand64(), m.va);
   endtask

   // translate a known page at a random offset, sometimes with one index bit flipped
   task automatic translate_known();
      la_type va;
      int     bit_pos;
      if (known_maps.size() == 0) begin
         va = la_type'(rand64());
      end else begin
         va = known_maps[$urandom_range(known_maps.size() - 1)].va;
         va[OFFSET_W-1:0] = OFFSET_W'($urandom);
         if ($urandom_range(99) < 15) begin
            bit_pos     = $urandom_range(LA_W - 1, OFFSET_W);
            va[bit_pos] = ~va[bit_pos];
         end
      end
      send_item(CMD_XLATE, entry_addr_type'(rand64()), rand64(), va);
   endtask

   task automatic run_random_block(input int target);
      int            pick;
      int            lvl;
      page_map_type  m;
      entry_val_type pte;
      while (items_sent < target) begin
         pick = $urandom_range(99);
         if (pick < 35) begin
            map_new_page();
         end else if (pick < 70) begin
            translate_known();
         end else if (pick < 80 && known_maps.size() > 0) begin
            // overwrite one level of a known page, the newer entry must win
            m   = known_maps[$urandom_range(known_maps.size() - 1)];
            lvl = $urandom_range(LEVELS - 1);
            pte = rand64();
            pte[PRESENT_BIT] = ($urandom_range(99) < 70);
            send_item(CMD_LOAD, m.tbl[lvl] + (entry_addr_type'(idx_of(m.va, lvl)) << PTE_SHIFT),
                      pte, la_type'(rand64()));
            send_item(CMD_XLATE, entry_addr_type'(rand64()), rand64(), m.va);
         end else if (pick < 89) begin
            send_item(CMD_LOAD, entry_addr_type'(rand64()), rand64(), la_type'(rand64()));
         end else if (pick < 98) begin
            send_item(CMD_XLATE, entry_addr_type'(rand64()), rand64(), la_type'(rand64()));
         end else begin
            drain_results(0);
         end
      end
   endtask

   // stimulus and verdict
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed walks, root still at its reset value of zero
      // empty store: missing top level entry
      send_item(CMD_XLATE, '0, '0, '0);
      // entry with present clear and every other bit set
      send_item(CMD_LOAD, '0, 64'hFFFF_FFFF_FFFF_FFFE, '1);
      send_item(CMD_XLATE, '1, '1, '0);
      // same address again, newest wins: frame zero at every level
      send_item(CMD_LOAD, '0, 64'h1, '0);
      send_item(CMD_XLATE, '0, '0, '0);
      send_item(CMD_XLATE, '0, '0, 48'h0000_0000_0FFF);
      // all-ones entry: top frame, second level missing
      send_item(CMD_LOAD, '0, '1, '0);
      send_item(CMD_XLATE, '0, '0, {9'h000, 27'h7FF_FFFF, 12'hABC});
      // highest table slot below 2^52 points back at the top frame
      send_item(CMD_LOAD, 53'h0F_FFFF_FFFF_FFF8, '1, '0);
      send_item(CMD_XLATE, '0, '0, {9'h000, 27'h7FF_FFFF, 12'hFFF});
      send_item(CMD_XLATE, '0, '0, '1);
      // bits above the frame field are ignored
      send_item(CMD_LOAD, 53'h0FF8, 64'hFFFF_FFFF_FFFF_F001, '0);
      send_item(CMD_XLATE, '0, '0, '1);
      // widest entry address, never reached by this root
      send_item(CMD_LOAD, 53'h1F_FFFF_FFFF_FFFF, '0, '1);
      send_item(CMD_XLATE, '0, '0, {9'h1FF, 27'h000_0000, 12'h123});
      // present cleared at the second level
      send_item(CMD_LOAD, 53'h0F_FFFF_FFFF_FFF8, 64'hFFFF_FFFF_FFFF_FFFE, '0);
      send_item(CMD_XLATE, '0, '0, '1);
      drain_results(SETTLE_CYCLES);

      // top-of-range root, slot addresses carry into bit 52; long result hold first
      write_root(ROOT_MAX);
      hold_asked <= hold_asked + 1;
      run_random_block(200);
      drain_results(SETTLE_CYCLES);

      // zero root, starting with a stretch without idling on either side
      write_root('0);
      no_stall <= 1'b1;
      run_random_block(300);
      no_stall <= 1'b0;
      run_random_block(390);
      drain_results(SETTLE_CYCLES);

      // random root
      write_root(pa_type'(rand64()));
      run_random_block(545);

      // fill the store past capacity, the extra loads are dropped
      while (loads_sent < STORE_DEPTH + 6) begin
         map_new_page();
      end
      repeat (12) translate_known();
      drain_results(SETTLE_CYCLES);

      @(negedge clock);
      if (mismatch_count == 0 && results_owed == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+design
design/ptw_pkg.sv
design/ptw_ram.sv
design/four_level_page_table_walk_core.sv
design/ptw_checker.sv
bench/ptw_walk_checker.sv
bench/tb_four_level_page_table_walk_core.sv
